FILE: rtl/adler32_checksum_8lane_macros.svh
// Assertion helpers for the checksum block.
// Each expects signals named clk and arst_n in the scope of use.
`ifndef ADLER32_CHECKSUM_8LANE_MACROS_SVH
`define ADLER32_CHECKSUM_8LANE_MACROS_SVH

// Same-cycle implication
`define ADL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ADL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/adl_pkg.sv
package adl_pkg;

	// Lane count bounds and default
	localparam int LANES_DEF = 8;
	localparam int MAX_LANES = 8;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = MAX_LANES * BYTE_W;
	localparam int COUNT_W = 4;
	localparam int SEED_W  = 32;
	localparam int SUM_W   = 16;
	localparam int CHK_W   = 2 * SUM_W;

	// Stream data word: data_bytes, byte_count, seed, padded to bytes
	localparam int TDATA_RAW_W = DATA_W + COUNT_W + SEED_W;
	localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;

	// Adler modulus and the residue of 2^16 used to fold sum B
	localparam int unsigned ADLER_MOD = 32'd65521;
	localparam int unsigned ADL_FOLD  = (32'd1 << SUM_W) % ADLER_MOD;

	// Per-item side information carried down the pipeline
	typedef struct packed {
		logic              first;
		logic              last;
		logic [SEED_W-1:0] seed;
	} meta_t;

	// Stage enables from the top-level flow control
	typedef struct packed {
		logic tree_en;
		logic acc_en;
	} ctrl_t;

endpackage

FILE: rtl/adl_lane.sv
module adl_lane #(
	parameter int IDX = 0,
	parameter int NW  = 4
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [NW-1:0]                  n,
	input  logic [adl_pkg::BYTE_W-1:0]     data_byte,
	output logic [adl_pkg::BYTE_W-1:0]     byte_s1,
	output logic [adl_pkg::BYTE_W+NW-1:0]  wbyte_s1
);

	logic                          lane_on;
	logic [NW-1:0]                 weight;
	logic [adl_pkg::BYTE_W-1:0]    byte_m;

	// Byte counts toward sum A once and toward sum B (n - IDX) times
	assign lane_on = (n > NW'(IDX));
	assign weight  = lane_on ? (n - NW'(IDX)) : '0;
	assign byte_m  = lane_on ? data_byte : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1  <= byte_m;
			wbyte_s1 <= (adl_pkg::BYTE_W + NW)'(byte_m) * (adl_pkg::BYTE_W + NW)'(weight);
		end
	end

endmodule

FILE: rtl/adl_merge.sv
module adl_merge #(
	parameter int LANES = adl_pkg::LANES_DEF,
	parameter int NW    = 4
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  adl_pkg::ctrl_t                               ctrl,
	input  logic [LANES-1:0][adl_pkg::BYTE_W-1:0]        byte_s1,
	input  logic [LANES-1:0][adl_pkg::BYTE_W+NW-1:0]     wbyte_s1,
	input  adl_pkg::meta_t                               meta_s1,
	input  logic [NW-1:0]                                n_s1,
	output logic                                         last_s2,
	output logic [adl_pkg::CHK_W-1:0]                    chk_next
);

	localparam int SW  = adl_pkg::BYTE_W + $clog2(LANES + 1);
	localparam int WW  = adl_pkg::BYTE_W + $clog2(LANES * (LANES + 1) / 2 + 1);
	localparam int AW  = adl_pkg::SUM_W + 1;
	localparam int BW  = adl_pkg::SUM_W + NW + 1;
	localparam int HW  = BW - adl_pkg::SUM_W;
	localparam int FW  = 5;

	logic [SW-1:0]              s_sum, s_sum_s2;
	logic [WW-1:0]              w_sum, w_sum_s2;
	adl_pkg::meta_t             meta_s2;
	logic [NW-1:0]              n_s2;
	logic [adl_pkg::SUM_W-1:0]  sum_a_q, sum_b_q;
	logic [adl_pkg::SUM_W-1:0]  a0, b0, a_mod, b_mod;
	logic [AW-1:0]              a_raw;
	logic [BW-1:0]              b_raw;
	logic [AW-1:0]              b_fold;

	// Sum of lane bytes and of weighted lane bytes
	always_comb begin
		s_sum = '0;
		w_sum = '0;
		for (int k = 0; k < LANES; k++) begin
			s_sum = s_sum + SW'(byte_s1[k]);
			w_sum = w_sum + WW'(wbyte_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tree_en) begin
			s_sum_s2 <= s_sum;
			w_sum_s2 <= w_sum;
			meta_s2  <= meta_s1;
			n_s2     <= n_s1;
		end
	end

	// Starting sums: seed on a first item, else the running state
	assign a0 = meta_s2.first ? meta_s2.seed[adl_pkg::SUM_W-1:0] : sum_a_q;
	assign b0 = meta_s2.first ? meta_s2.seed[adl_pkg::SEED_W-1:adl_pkg::SUM_W] : sum_b_q;

	// A grows by the byte sum, B by n copies of A plus the weighted sum
	assign a_raw = AW'(a0) + AW'(s_sum_s2);
	assign b_raw = BW'(b0) + BW'(n_s2) * BW'(a0) + BW'(w_sum_s2);

	// Fold B from bit 16 up (2^16 is 15 mod 65521), then one subtract each
	assign b_fold = AW'(b_raw[adl_pkg::SUM_W-1:0])
		+ AW'(FW'(adl_pkg::ADL_FOLD)) * AW'(b_raw[BW-1:adl_pkg::SUM_W]);
	assign a_mod = (a_raw >= AW'(adl_pkg::ADLER_MOD))
		? adl_pkg::SUM_W'(a_raw - AW'(adl_pkg::ADLER_MOD)) : adl_pkg::SUM_W'(a_raw);
	assign b_mod = (b_fold >= AW'(adl_pkg::ADLER_MOD))
		? adl_pkg::SUM_W'(b_fold - AW'(adl_pkg::ADLER_MOD)) : adl_pkg::SUM_W'(b_fold);

	// Running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= adl_pkg::SUM_W'(1);
			sum_b_q <= '0;
		end else if (ctrl.acc_en) begin
			sum_a_q <= a_mod;
			sum_b_q <= b_mod;
		end
	end

	assign last_s2  = meta_s2.last;
	assign chk_next = {b_mod, a_mod};

	// HW is only a sanity bound on the folded high part
	if (HW > FW) begin : g_bad_width
		$error("fold width too narrow for LANES");
	end

endmodule

FILE: rtl/adler32_checksum_8lane.sv
// Adler-32 checksum engine taking up to LANES message bytes per item, lowest
// byte first. Set first on the item that opens a message to load the sums
// from seed (sum B in bits 31:16, sum A in 15:0); without it an item
// continues from the current sums, which start at 1 and 0 after reset. A
// byte_count above LANES counts as LANES. The item marked with tlast yields
// one checksum item; other items yield nothing. Sustained rate is one item
// per clock unless a final item waits for the output register: the lanes and
// the byte-sum tree are pipelined, and the only loop is the modular update of
// the two running sums. A checksum passes the lane, tree and output registers
// to m_tvalid, and a waiting one does not stop items that are not final.
`include "adler32_checksum_8lane_macros.svh"

module adler32_checksum_8lane #(
	parameter int LANES = adl_pkg::LANES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// data_bytes [63:0], byte_count [67:64], seed [99:68], zero pad above
	input  logic [adl_pkg::TDATA_W-1:0] s_tdata,
	// first
	input  logic                        s_tuser,
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// checksum [31:0]
	output logic [adl_pkg::CHK_W-1:0]   m_tdata
);

	localparam int NW = $clog2(LANES + 1);
	localparam int CNT_LO  = adl_pkg::DATA_W;
	localparam int SEED_LO = adl_pkg::DATA_W + adl_pkg::COUNT_W;

	logic [adl_pkg::COUNT_W-1:0]                   byte_count;
	logic [NW-1:0]                                 n_in, n_s1;
	adl_pkg::meta_t                                meta_in, meta_s1;
	logic                                          valid_s1, valid_s2;
	logic                                          out_valid_q;
	logic [adl_pkg::CHK_W-1:0]                     checksum_q;
	logic                                          in_fire, s1_ready, s2_ready;
	logic                                          acc_fire, out_free, last_s2;
	adl_pkg::ctrl_t                                ctrl;
	logic [LANES-1:0][adl_pkg::BYTE_W-1:0]         lane_byte_s1;
	logic [LANES-1:0][adl_pkg::BYTE_W+NW-1:0]      lane_wbyte_s1;
	logic [adl_pkg::CHK_W-1:0]                     chk_next;

	// Input unpacking and byte count clamp
	assign byte_count   = s_tdata[SEED_LO-1:CNT_LO];
	assign n_in         = (byte_count > adl_pkg::COUNT_W'(LANES))
		? NW'(LANES) : NW'(byte_count);
	assign meta_in.first = s_tuser;
	assign meta_in.last  = s_tlast;
	assign meta_in.seed  = s_tdata[SEED_LO+adl_pkg::SEED_W-1:SEED_LO];

	// Flow control: only a final item waits for the output register
	assign out_free = !out_valid_q || m_tready;
	assign acc_fire = valid_s2 && (!last_s2 || out_free);
	assign s2_ready = !valid_s2 || acc_fire;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_tready = s1_ready;
	assign in_fire  = s_tvalid && s1_ready;

	assign ctrl.tree_en = valid_s1 && s2_ready;
	assign ctrl.acc_en  = acc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= s_tvalid;
			if (s2_ready)
				valid_s2 <= valid_s1;
			if (acc_fire && last_s2)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Side information for stage 1
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meta_s1 <= meta_in;
			n_s1    <= n_in;
		end
	end

	// One lane per byte position
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		adl_lane #(
			.IDX (k),
			.NW  (NW)
		) u_lane (
			.clk       (clk),
			.en        (in_fire),
			.n         (n_in),
			.data_byte (s_tdata[k*adl_pkg::BYTE_W +: adl_pkg::BYTE_W]),
			.byte_s1   (lane_byte_s1[k]),
			.wbyte_s1  (lane_wbyte_s1[k])
		);
	end

	// Lane merge and running-sum update
	adl_merge #(
		.LANES (LANES),
		.NW    (NW)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.byte_s1  (lane_byte_s1),
		.wbyte_s1 (lane_wbyte_s1),
		.meta_s1  (meta_s1),
		.n_s1     (n_s1),
		.last_s2  (last_s2),
		.chk_next (chk_next)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (acc_fire && last_s2)
			checksum_q <= chk_next;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = checksum_q;

	`ADL_ASSERT_NXT(a_out_shown_c, acc_fire && last_s2, m_tvalid, "final item gave no checksum")
	`ADL_ASSERT_NXT(a_out_reduced_c, acc_fire && last_s2, (m_tdata[15:0] < 16'd65521) && (m_tdata[31:16] < 16'd65521), "checksum halves not reduced")
	`ADL_ASSERT_NXT(a_final_held_c, valid_s2 && last_s2 && out_valid_q && !m_tready, valid_s2 && last_s2, "stalled final item lost")
	`ADL_ASSERT_IMP(a_no_drop_c, valid_s1 && !s2_ready, !s_tready, "input taken over a full stage 1")

endmodule
